FILE: hw/rtl/sdll_pkg.sv
package sdll_pkg;
    localparam int SLOTS = 8;
    localparam int SW = $clog2(SLOTS);
    localparam int LW = SW + 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] NIL = LW'(SLOTS);

    typedef enum logic [3:0] {
        OP_ADD_FIRST = 4'd0, OP_ADD_AFTER = 4'd1, OP_ADD_LAST = 4'd2,
        OP_DEL_FIRST = 4'd3, OP_DEL_AFTER = 4'd4, OP_DEL_LAST = 4'd5,
        OP_DEL_ALL = 4'd6, OP_WALK_FWD = 4'd7, OP_WALK_REV = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2, ST_NOPOS = 3'd3,
        ST_NOAFTER = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_LINK, S_LINK_NB, S_AFTER, S_UNLINK, S_WALK_RD, S_WALK_OUT, S_RESP
    } t_state;

    typedef struct packed {
        logic [3:0]    operation;
        logic [SW-1:0] position;
        logic [63:0]   id_word;
        logic [63:0]   name_word;
        logic [31:0]   amount;
    } t_in;

    typedef struct packed {
        logic [SW-1:0] slot;
        logic [63:0]   rec_id;
        logic [63:0]   rec_name;
        logic [31:0]   rec_amount;
        logic [CW-1:0] used_count;
        logic [2:0]    status;
        logic          last;
    } t_out;
endpackage

FILE: hw/rtl/sdll_stream_if.sv
interface sdll_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/slot_doubly_linked_list.sv
// Channel | Dir | Beat fields
// i_req   | in  | operation, position, id_word, name_word, amount
// o_rsp   | out | slot, rec_id, rec_name, rec_amount, used_count, status, last
// One request at a time, taken only in idle. Status-only answers and delete-all
// answer directly; delete head or tail unlinks, then answers; delete-after reads
// the successor, then unlinks (or answers nothing-after); add writes the slot,
// then the neighbours; walks read link and record, then send an output beat, per record.
// Reset clears head, tail, count, used bits and output valid; memories are not.
// A held output beat stalls the next response or walk beat until it is taken.
module slot_doubly_linked_list import sdll_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sdll_stream_if.sink   i_req,
    sdll_stream_if.source o_rsp
);
    logic [LW-1:0] m_next [SLOTS];
    logic [LW-1:0] m_prev [SLOTS];
    logic [159:0]  m_rec  [SLOTS];

    t_state r_state, n_state;
    logic [LW-1:0] r_head, n_head, r_tail, n_tail;
    logic [SLOTS-1:0] r_used, n_used;
    logic [CW-1:0] r_count, n_count;
    t_in r_in, n_in;
    logic [SW-1:0] r_s, n_s;
    logic [LW-1:0] r_p, n_p, r_n, n_n, r_cur, n_cur;
    logic [CW-1:0] r_k, n_k;
    logic r_fwd, n_fwd;
    logic [SW-1:0] r_slot, n_slot;
    t_status r_status, n_status;
    t_out r_out, n_out;
    logic r_ov, n_ov;
    logic [LW-1:0] r_rd_next, r_rd_prev;
    logic [159:0] r_rd_rec;

    logic          w_next_we, w_prev_we, w_rec_we;
    logic [SW-1:0] w_next_wa, w_prev_wa, w_rec_wa;
    logic [LW-1:0] w_next_wd, w_prev_wd;
    logic [159:0]  w_rec_wd;

    logic [3:0]    w_op;
    logic [LW-1:0] w_pos, w_end, w_p, w_cur, w_free, w_walk_n;
    logic          w_go, w_fin, w_out_free;
    t_status       w_status;

    function automatic logic in_list(logic [LW-1:0] s, logic [SLOTS-1:0] u);
        return (s < NIL) && u[s[SW-1:0]];
    endfunction

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_out;

    always_comb begin
        w_free = NIL;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (!r_used[i]) w_free = LW'(i);
    end

    assign w_out_free = !r_ov || o_rsp.ready;
    assign w_op  = i_req.data.operation;
    assign w_pos = {1'b0, i_req.data.position};
    assign w_end = (w_op == OP_DEL_FIRST || w_op == OP_WALK_FWD) ? r_head : r_tail;
    assign w_walk_n = r_fwd ? r_rd_next : r_rd_prev;
    assign w_fin = !in_list(w_walk_n, r_used) || (r_k == CW'(SLOTS - 1));

    // request decode: does the operation go on, and what it answers if not
    always_comb begin
        w_go = 1'b1;
        w_status = ST_OK;
        w_p = NIL;
        w_cur = w_end;
        case (w_op)
            OP_ADD_FIRST, OP_ADD_AFTER, OP_ADD_LAST: begin
                if (w_op == OP_ADD_AFTER) w_p = w_pos;
                else if (w_op == OP_ADD_LAST && r_count != '0) w_p = r_tail;
                w_cur = w_p;
                if (w_free == NIL) begin
                    w_go = 1'b0;
                    w_status = ST_FULL;
                end else if (w_op == OP_ADD_AFTER && !in_list(w_pos, r_used)) begin
                    w_go = 1'b0;
                    w_status = ST_NOPOS;
                end
            end
            OP_DEL_AFTER: begin
                w_cur = w_pos;
                if (!in_list(w_pos, r_used)) begin
                    w_go = 1'b0;
                    w_status = ST_NOPOS;
                end
            end
            OP_DEL_FIRST, OP_DEL_LAST, OP_WALK_FWD, OP_WALK_REV: begin
                if (r_count == '0 || !in_list(w_end, r_used)) begin
                    w_go = 1'b0;
                    w_status = ST_EMPTY;
                end
            end
            // delete-all and unknown codes answer at once
            default: w_go = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_req.valid) begin
                if (!w_go) n_state = S_RESP;
                else begin
                    case (w_op)
                        OP_ADD_FIRST, OP_ADD_AFTER, OP_ADD_LAST: n_state = S_LINK;
                        OP_DEL_AFTER:             n_state = S_AFTER;
                        OP_DEL_FIRST, OP_DEL_LAST: n_state = S_UNLINK;
                        OP_WALK_FWD, OP_WALK_REV: n_state = S_WALK_RD;
                        default:                  n_state = S_RESP;
                    endcase
                end
            end
            S_LINK:     n_state = S_LINK_NB;
            S_LINK_NB:  n_state = S_RESP;
            S_AFTER:    n_state = in_list(r_rd_next, r_used) ? S_UNLINK : S_RESP;
            S_UNLINK:   n_state = S_RESP;
            S_WALK_RD:  n_state = S_WALK_OUT;
            S_WALK_OUT: if (w_out_free) n_state = w_fin ? S_IDLE : S_WALK_RD;
            S_RESP:     if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_used = r_used;
        n_count = r_count;
        n_in = r_in;
        n_s = r_s;
        n_p = r_p;
        n_n = r_n;
        n_cur = r_cur;
        n_k = r_k;
        n_fwd = r_fwd;
        n_slot = r_slot;
        n_status = r_status;
        n_out = r_out;
        n_ov = r_ov && !o_rsp.ready;
        w_next_we = 1'b0;
        w_next_wa = '0;
        w_next_wd = '0;
        w_prev_we = 1'b0;
        w_prev_wa = '0;
        w_prev_wd = '0;
        w_rec_we = 1'b0;
        w_rec_wa = '0;
        w_rec_wd = '0;
        case (r_state)
            S_IDLE: if (i_req.valid) begin
                n_in = i_req.data;
                n_slot = '0;
                n_status = w_status;
                n_p = w_p;
                n_cur = w_cur;
                n_s = w_free[SW-1:0];
                n_k = '0;
                n_fwd = (w_op == OP_WALK_FWD);
                if (w_op == OP_DEL_ALL) begin
                    n_used = '0;
                    n_head = NIL;
                    n_tail = NIL;
                    n_count = '0;
                end
            end
            S_LINK: begin
                // r_rd_next holds next of p when p is a slot
                n_n = (r_p == NIL) ? r_head : r_rd_next;
                w_prev_we = 1'b1;
                w_prev_wa = r_s;
                w_prev_wd = r_p;
                w_next_we = 1'b1;
                w_next_wa = r_s;
                w_next_wd = n_n;
                w_rec_we = 1'b1;
                w_rec_wa = r_s;
                w_rec_wd = {r_in.id_word, r_in.name_word, r_in.amount};
                if (r_p == NIL) n_head = {1'b0, r_s};
                if (n_n >= NIL) n_tail = {1'b0, r_s};
                n_used[r_s] = 1'b1;
                n_count = r_count + 1'b1;
                n_slot = r_s;
            end
            S_LINK_NB: begin
                // point the neighbours at the new slot
                if (r_p != NIL) begin
                    w_next_we = 1'b1;
                    w_next_wa = r_p[SW-1:0];
                    w_next_wd = {1'b0, r_s};
                end
                if (r_n < NIL) begin
                    w_prev_we = 1'b1;
                    w_prev_wa = r_n[SW-1:0];
                    w_prev_wd = {1'b0, r_s};
                end
            end
            S_AFTER: begin
                if (in_list(r_rd_next, r_used)) n_cur = r_rd_next;
                else n_status = ST_NOAFTER;
            end
            S_UNLINK: begin
                if (r_rd_prev < NIL) begin
                    w_next_we = 1'b1;
                    w_next_wa = r_rd_prev[SW-1:0];
                    w_next_wd = r_rd_next;
                end else begin
                    n_head = (r_rd_next < NIL) ? r_rd_next : NIL;
                end
                if (r_rd_next < NIL) begin
                    w_prev_we = 1'b1;
                    w_prev_wa = r_rd_next[SW-1:0];
                    w_prev_wd = r_rd_prev;
                end else begin
                    n_tail = (r_rd_prev < NIL) ? r_rd_prev : NIL;
                end
                n_used[r_cur[SW-1:0]] = 1'b0;
                if (r_count != '0) n_count = r_count - 1'b1;
                n_slot = r_cur[SW-1:0];
            end
            S_WALK_RD: ;
            S_WALK_OUT: if (w_out_free) begin
                n_out.slot = r_cur[SW-1:0];
                n_out.rec_id = r_rd_rec[159:96];
                n_out.rec_name = r_rd_rec[95:32];
                n_out.rec_amount = r_rd_rec[31:0];
                n_out.used_count = r_count;
                n_out.status = ST_OK;
                n_out.last = w_fin;
                n_ov = 1'b1;
                n_k = r_k + 1'b1;
                n_cur = w_walk_n;
            end
            S_RESP: if (w_out_free) begin
                n_out = '0;
                n_out.slot = r_slot;
                n_out.used_count = r_count;
                n_out.status = r_status;
                n_out.last = 1'b1;
                n_ov = 1'b1;
            end
            default: ;
        endcase
    end

    // read at the next cursor so data is ready the cycle after
    always_ff @(posedge i_clk) begin
        if (w_next_we) m_next[w_next_wa] <= w_next_wd;
        if (w_prev_we) m_prev[w_prev_wa] <= w_prev_wd;
        if (w_rec_we)  m_rec[w_rec_wa] <= w_rec_wd;
        r_rd_next <= m_next[n_cur[SW-1:0]];
        r_rd_prev <= m_prev[n_cur[SW-1:0]];
        r_rd_rec  <= m_rec[n_cur[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= NIL;
            r_tail <= NIL;
            r_used <= '0;
            r_count <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head <= n_head;
            r_tail <= n_tail;
            r_used <= n_used;
            r_count <= n_count;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
        r_s <= n_s;
        r_p <= n_p;
        r_n <= n_n;
        r_cur <= n_cur;
        r_k <= n_k;
        r_fwd <= n_fwd;
        r_slot <= n_slot;
        r_status <= n_status;
        r_out <= n_out;
    end
endmodule

FILE: hw/rtl/sdll_checker.sv
module sdll_assert import sdll_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic o_rsp_valid,
    input logic o_rsp_ready,
    input t_out o_rsp_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid && $stable(o_rsp_data))
        else $error("output beat dropped");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp_data.used_count <= CW'(SLOTS))
        else $error("count out of range");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_data.last |-> !i_req_ready)
        else $error("accept during walk");
endmodule

bind slot_doubly_linked_list sdll_assert u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_req_valid(i_req.valid), .i_req_ready(i_req.ready),
    .o_rsp_valid(o_rsp.valid), .o_rsp_ready(o_rsp.ready),
    .o_rsp_data(o_rsp.data)
);

FILE: tb/sdll_checker.sv
module sdll_checker import sdll_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_in  i_req_data,
    input  logic i_rsp_valid,
    input  logic i_rsp_ready,
    input  t_out i_rsp_data,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [LW-1:0] head, tail;
    logic [LW-1:0] nxt [SLOTS];
    logic [LW-1:0] prv [SLOTS];
    logic          used [SLOTS];
    logic [63:0]   rid [SLOTS];
    logic [63:0]   rname [SLOTS];
    logic [31:0]   ramt [SLOTS];
    logic [CW-1:0] count;
    t_out          expected_rsp [$];

    assign o_pending = expected_rsp.size();

    function automatic bit live(logic [LW-1:0] s);
        return s < SLOTS && used[s[SW-1:0]];
    endfunction

    function automatic void push_status(logic [SW-1:0] s, t_status st);
        t_out r;
        r = '0;
        r.slot = s;
        r.used_count = count;
        r.status = st;
        r.last = 1'b1;
        expected_rsp.push_back(r);
    endfunction

    function automatic void unlink(logic [LW-1:0] s);
        logic [LW-1:0] p, n;
        p = prv[s];
        n = nxt[s];
        if (p < SLOTS) nxt[p] = n;
        else head = (n < SLOTS) ? n : NIL;
        if (n < SLOTS) prv[n] = p;
        else tail = (p < SLOTS) ? p : NIL;
        used[s] = 1'b0;
        if (count > 0) count--;
    endfunction

    function automatic void predict_request(t_in q);
        logic [LW-1:0] s, p, n;
        t_out r;
        int k;
        s = NIL;
        case (q.operation)
            OP_ADD_FIRST, OP_ADD_AFTER, OP_ADD_LAST: begin
                for (int i = SLOTS - 1; i >= 0; i--) if (!used[i]) s = LW'(i);
                if (s == NIL) begin
                    push_status('0, ST_FULL);
                    return;
                end
                if (q.operation == OP_ADD_FIRST ||
                    (q.operation == OP_ADD_LAST && count == 0)) p = NIL;
                else if (q.operation == OP_ADD_LAST) p = tail;
                else begin
                    if (!live(LW'(q.position))) begin
                        push_status('0, ST_NOPOS);
                        return;
                    end
                    p = LW'(q.position);
                end
                rid[s] = q.id_word;
                rname[s] = q.name_word;
                ramt[s] = q.amount;
                n = (p == NIL) ? head : nxt[p];
                prv[s] = p;
                nxt[s] = n;
                if (p == NIL) head = s; else nxt[p] = s;
                if (n < SLOTS) prv[n] = s; else tail = s;
                used[s] = 1'b1;
                count++;
                push_status(s[SW-1:0], ST_OK);
            end
            OP_DEL_FIRST, OP_DEL_LAST: begin
                s = (q.operation == OP_DEL_FIRST) ? head : tail;
                if (count == 0 || !live(s)) push_status('0, ST_EMPTY);
                else begin
                    unlink(s);
                    push_status(s[SW-1:0], ST_OK);
                end
            end
            OP_DEL_AFTER: begin
                if (!live(LW'(q.position))) push_status('0, ST_NOPOS);
                else begin
                    s = nxt[q.position];
                    if (!live(s)) push_status('0, ST_NOAFTER);
                    else begin
                        unlink(s);
                        push_status(s[SW-1:0], ST_OK);
                    end
                end
            end
            OP_DEL_ALL: begin
                for (int i = 0; i < SLOTS; i++) used[i] = 1'b0;
                head = NIL;
                tail = NIL;
                count = '0;
                push_status('0, ST_OK);
            end
            OP_WALK_FWD, OP_WALK_REV: begin
                s = (q.operation == OP_WALK_FWD) ? head : tail;
                if (count == 0 || !live(s)) push_status('0, ST_EMPTY);
                else begin
                    k = 0;
                    while (live(s) && k < SLOTS) begin
                        n = (q.operation == OP_WALK_FWD) ? nxt[s] : prv[s];
                        r.slot = s[SW-1:0];
                        r.rec_id = rid[s];
                        r.rec_name = rname[s];
                        r.rec_amount = ramt[s];
                        r.used_count = count;
                        r.status = ST_OK;
                        r.last = !live(n) || k + 1 >= SLOTS;
                        expected_rsp.push_back(r);
                        k++;
                        s = n;
                    end
                end
            end
            default: push_status('0, ST_OK);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            head <= NIL;
            tail <= NIL;
            count <= '0;
            for (int i = 0; i < SLOTS; i++) used[i] <= 1'b0;
            o_fail_count <= 0;
        end else begin
            // compare before predicting: a result never leaves in the accept cycle
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_rsp.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected result beat %p", i_rsp_data);
                end else begin
                    exp_r = expected_rsp.pop_front();
                    if (exp_r !== i_rsp_data) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p got %p", exp_r, i_rsp_data);
                    end
                end
            end
            if (i_req_valid && i_req_ready) predict_request(i_req_data);
        end
    end
endmodule

FILE: tb/tb_slot_doubly_linked_list.sv
module tb_slot_doubly_linked_list import sdll_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   n_walks = 0;

    sdll_stream_if #(.T(t_in))  req_if ();
    sdll_stream_if #(.T(t_out)) rsp_if ();

    slot_doubly_linked_list i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source)
    );

    sdll_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(req_if.valid), .i_req_ready(req_if.ready), .i_req_data(req_if.data),
        .i_rsp_valid(rsp_if.valid), .i_rsp_ready(rsp_if.ready), .i_rsp_data(rsp_if.data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("[slot_doubly_linked_list] ERROR");
            $finish;
        end
    end

    // random stall on the result side, with calm stretches
    initial begin
        int gap;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_if.valid && !rsp_if.ready) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
                if (cycle_count % 3000 < 500) gap = 0;
                repeat (gap) @(negedge i_clk);
                rsp_if.ready <= 1'b1;
            end else if (rsp_if.ready && !(rsp_if.valid)) begin
                rsp_if.ready <= rsp_if.ready;
            end else if (rsp_if.ready) begin
                rsp_if.ready <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    // valid stays high between back-to-back beats; drop it only for a gap
    task automatic send_beat(t_op op, logic [SW-1:0] pos, logic [63:0] id,
                             logic [63:0] nm, logic [31:0] amt, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.data <= {op, pos, id, nm, amt};
        req_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (op == OP_WALK_FWD || op == OP_WALK_REV) n_walks++;
    endtask

    task automatic drop_req();
        req_if.valid <= 1'b0;
    endtask

    task automatic send_raw(logic [3:0] op);
        send_beat(t_op'(op), 3'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                  $urandom, 1'b0);
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        t_op op;
        bit calm;
        req_if.valid = 1'b0;
        req_if.data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty-list answers, fill to full, edges of each delete
        send_beat(OP_DEL_FIRST, 0, 0, 0, 0, 0);
        send_beat(OP_DEL_LAST, 0, 0, 0, 0, 0);
        send_beat(OP_WALK_FWD, 0, 0, 0, 0, 0);
        send_beat(OP_WALK_REV, 0, 0, 0, 0, 0);
        send_beat(OP_DEL_AFTER, 3, 0, 0, 0, 0);
        send_beat(OP_ADD_AFTER, 0, 1, 1, 1, 0);
        send_beat(OP_DEL_ALL, 0, 0, 0, 0, 0);
        send_beat(OP_ADD_LAST, 0, '1, '0, 32'h8000_0000, 0);
        send_beat(OP_ADD_FIRST, 0, '0, '1, 32'h7fff_ffff, 0);
        send_beat(OP_ADD_AFTER, 0, 64'h5555, 64'haaaa, 32'hffff_ffff, 0);
        for (int i = 0; i < 5; i++)
            send_beat(OP_ADD_LAST, 0, rand64(), rand64(), $urandom, 0);
        send_beat(OP_ADD_FIRST, 0, 0, 0, 0, 0);
        send_beat(OP_ADD_AFTER, 1, 0, 0, 0, 0);
        send_beat(OP_WALK_FWD, 0, 0, 0, 0, 0);
        send_beat(OP_WALK_REV, 0, 0, 0, 0, 0);
        send_beat(OP_DEL_AFTER, 7, 0, 0, 0, 0);
        send_beat(OP_DEL_FIRST, 0, 0, 0, 0, 0);
        send_beat(OP_DEL_LAST, 0, 0, 0, 0, 0);
        send_beat(OP_DEL_AFTER, 1, 0, 0, 0, 0);
        send_raw(4'd15);
        send_raw(4'd9);
        drop_req();

        // hold until the block has drained
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        send_beat(OP_DEL_ALL, 0, 0, 0, 0, 1);

        for (int i = 0; i < 360; i++) begin
            calm = (i % 60) < 10;
            case ($urandom_range(0, 19))
                0, 1, 2, 3: op = OP_ADD_LAST;
                4, 5: op = OP_ADD_FIRST;
                6, 7, 8: op = OP_ADD_AFTER;
                9, 10: op = OP_DEL_FIRST;
                11: op = OP_DEL_LAST;
                12, 13: op = OP_DEL_AFTER;
                14: op = ($urandom_range(0, 5) == 0) ? OP_DEL_ALL : OP_ADD_LAST;
                15, 16: op = OP_WALK_FWD;
                17: op = OP_WALK_REV;
                default: op = t_op'($urandom_range(0, 15));
            endcase
            send_beat(op, 3'($urandom), rand64(), rand64(), $urandom, calm);
        end
        drop_req();

        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        $display("Ran directed and 360 random requests, %0d walks, over %0d cycles.",
                 n_walks, cycle_count);
        if (fail_count == 0) begin
            $display("[slot_doubly_linked_list] OK");
        end else begin
            $display("[slot_doubly_linked_list] ERROR");
        end
        $finish;
    end
endmodule
